[rtl/lzss_stream_decoder_core_assert.svh]
// assertion macros shared by the checker
`ifndef LZSS_STREAM_DECODER_CORE_ASSERT_SVH
`define LZSS_STREAM_DECODER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define LZSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define LZSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lzsd_pkg.sv]
`default_nettype none
package lzsd_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int HIST_AW     = $clog2(WINDOW_SIZE);
  localparam int MIN_LEN     = 3;
  localparam int CNT_W       = 32;
  localparam int LEN_W       = 5;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TRUNC    = 2'd1,
    STAT_BAD_REF  = 2'd2,
    STAT_CAPACITY = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    PH_FLAG   = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECODE = 2'd1,
    S_COPY   = 2'd2,
    S_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    logic  in_load;
    logic  set_flag;
    logic  set_offset;
    logic  next_tok;
    logic  close;
    logic  set_hold;
    logic  start_copy;
    logic  copy_step;
    logic  out_load;
    kind_t out_kind;
    stat_t out_status;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic   out_free;
    logic   eos;
    logic   err_hold;
    phase_t phase;
    logic   tok_match;
    logic   lit_cap_ok;
    logic   match_cap_ok;
    logic   ref_ok;
    logic   copy_last;
  } stat_bus_t;

endpackage
`default_nettype wire

[rtl/lzsd_ctrl.sv]
`default_nettype none
module lzsd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lzsd_pkg::stat_bus_t sts,
  output lzsd_pkg::cmd_t         cmd
);

  lzsd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzsd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.out_kind   = lzsd_pkg::KIND_DATA;
    cmd.out_status = lzsd_pkg::STAT_OK;
    in_ready       = (state == lzsd_pkg::S_IDLE);
    case (state)
      lzsd_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = lzsd_pkg::S_DECODE;
        end
      end
      lzsd_pkg::S_DECODE: begin
        if (sts.out_free) begin
          state_next = lzsd_pkg::S_IDLE;
          if (sts.err_hold) begin
            // dropping bytes until the stream closes
            cmd.close = sts.eos;
          end else begin
            case (sts.phase)
              lzsd_pkg::PH_TOKEN: begin
                if (sts.tok_match) begin
                  cmd.set_offset = 1'b1;
                  if (sts.eos) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = lzsd_pkg::KIND_ERROR;
                    cmd.out_status = lzsd_pkg::STAT_TRUNC;
                    cmd.out_last   = 1'b1;
                    cmd.close      = 1'b1;
                  end
                end else if (!sts.lit_cap_ok) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_kind   = lzsd_pkg::KIND_ERROR;
                  cmd.out_status = lzsd_pkg::STAT_CAPACITY;
                  cmd.out_last   = 1'b1;
                  cmd.close      = sts.eos;
                  cmd.set_hold   = !sts.eos;
                end else begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = !sts.eos;
                  cmd.next_tok = 1'b1;
                  if (sts.eos) begin
                    state_next = lzsd_pkg::S_FINISH;
                  end
                end
              end
              lzsd_pkg::PH_SECOND: begin
                if (!sts.ref_ok || !sts.lit_cap_ok || !sts.match_cap_ok) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_kind   = lzsd_pkg::KIND_ERROR;
                  cmd.out_status = sts.ref_ok ? lzsd_pkg::STAT_CAPACITY
                                              : lzsd_pkg::STAT_BAD_REF;
                  cmd.out_last   = 1'b1;
                  cmd.close      = sts.eos;
                  cmd.set_hold   = !sts.eos;
                end else begin
                  cmd.start_copy = 1'b1;
                  state_next     = lzsd_pkg::S_COPY;
                end
              end
              default: begin
                // flag byte, also taken for the unused phase code
                cmd.set_flag = 1'b1;
                if (sts.eos) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = lzsd_pkg::KIND_FINISH;
                  cmd.out_last = 1'b1;
                  cmd.close    = 1'b1;
                end
              end
            endcase
          end
        end
      end
      lzsd_pkg::S_COPY: begin
        if (sts.out_free) begin
          cmd.copy_step = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_last  = sts.copy_last && !sts.eos;
          if (sts.copy_last) begin
            cmd.next_tok = 1'b1;
            state_next   = sts.eos ? lzsd_pkg::S_FINISH : lzsd_pkg::S_IDLE;
          end
        end
      end
      lzsd_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = lzsd_pkg::KIND_FINISH;
          cmd.out_last = 1'b1;
          cmd.close    = 1'b1;
          state_next   = lzsd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lzsd_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/lzsd_datapath.sv]
`default_nettype none
module lzsd_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lzsd_pkg::cmd_t       cmd,
  output lzsd_pkg::stat_bus_t       sts,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_eos,
  input  wire logic                 cfg_valid,
  input  wire logic [31:0]          cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lzsd_pkg::kind_t           out_kind,
  output logic [7:0]                out_byte,
  output lzsd_pkg::stat_t           out_status,
  output logic [31:0]               out_count,
  output logic                      out_last
);

  localparam int AW = lzsd_pkg::HIST_AW;

  // input holding registers
  logic [7:0] byte_q;
  logic       eos_q;

  // stream state
  logic [lzsd_pkg::CNT_W-1:0] wc;
  logic [lzsd_pkg::CNT_W-1:0] cap;
  logic [7:0]                 flag_bits;
  logic [2:0]                 tok_idx;
  lzsd_pkg::phase_t           phase;
  logic [7:0]                 off_low;
  logic                       err_hold;

  // copy engine
  logic [AW-1:0]                rd_ptr;
  logic [lzsd_pkg::LEN_W-1:0]   remaining;

  // history ring
  logic [7:0]    hist [lzsd_pkg::WINDOW_SIZE];
  logic [7:0]    hist_q;
  logic          byp;
  logic [7:0]    byp_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    copy_data;

  logic [AW:0]                  offset;
  logic [lzsd_pkg::LEN_W-1:0]   len;
  logic [lzsd_pkg::CNT_W:0]     lit_sum;
  logic [lzsd_pkg::CNT_W:0]     match_sum;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      byte_q <= in_byte;
      eos_q  <= in_eos;
    end
  end

  always_comb begin
    offset    = {1'b0, byte_q[7:4], off_low} + (AW+1)'(1);
    len       = lzsd_pkg::LEN_W'(byte_q[3:0]) + lzsd_pkg::LEN_W'(lzsd_pkg::MIN_LEN);
    lit_sum   = {1'b0, wc} + (lzsd_pkg::CNT_W+1)'(1);
    match_sum = {1'b0, wc} + (lzsd_pkg::CNT_W+1)'(len);
    copy_data = byp ? byp_data : hist_q;
    wr_en     = cmd.out_load && (cmd.out_kind == lzsd_pkg::KIND_DATA);
    wr_addr   = wc[AW-1:0];
    wr_data   = cmd.copy_step ? copy_data : byte_q;
    rd_en     = cmd.start_copy || (cmd.copy_step && (remaining != lzsd_pkg::LEN_W'(1)));
    rd_addr   = cmd.start_copy ? (wc[AW-1:0] - offset[AW-1:0]) : (rd_ptr + AW'(1));
  end

  always_comb begin
    sts.out_free     = !out_valid || out_ready;
    sts.eos          = eos_q;
    sts.err_hold     = err_hold;
    sts.phase        = phase;
    sts.tok_match    = flag_bits[tok_idx];
    sts.lit_cap_ok   = (lit_sum <= {1'b0, cap});
    sts.match_cap_ok = (match_sum <= {1'b0, cap});
    sts.ref_ok       = ({{(lzsd_pkg::CNT_W-AW-1){1'b0}}, offset} <= wc);
    sts.copy_last    = (remaining == lzsd_pkg::LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      hist_q <= hist[rd_addr];
    end
  end

  // a read of the address written in the same cycle takes the new byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr_data;
      rd_ptr   <= rd_addr;
    end
    if (cmd.start_copy) begin
      remaining <= len;
    end else if (cmd.copy_step) begin
      remaining <= remaining - lzsd_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= '1;
    end else if (cfg_valid) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc        <= '0;
      flag_bits <= '0;
      tok_idx   <= '0;
      phase     <= lzsd_pkg::PH_FLAG;
      off_low   <= '0;
      err_hold  <= 1'b0;
    end else begin
      if (cmd.set_flag) begin
        flag_bits <= byte_q;
        tok_idx   <= '0;
        phase     <= lzsd_pkg::PH_TOKEN;
      end
      if (cmd.set_offset) begin
        off_low <= byte_q;
        phase   <= lzsd_pkg::PH_SECOND;
      end
      if (cmd.next_tok) begin
        tok_idx <= tok_idx + 3'd1;
        phase   <= (tok_idx == 3'd7) ? lzsd_pkg::PH_FLAG : lzsd_pkg::PH_TOKEN;
      end
      if (cmd.set_hold) begin
        err_hold <= 1'b1;
      end
      if (wr_en) begin
        wc <= wc + lzsd_pkg::CNT_W'(1);
      end
      // closing the stream wins over everything above
      if (cmd.close) begin
        wc        <= '0;
        flag_bits <= '0;
        tok_idx   <= '0;
        phase     <= lzsd_pkg::PH_FLAG;
        off_low   <= '0;
        err_hold  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind   <= cmd.out_kind;
      out_byte   <= (cmd.out_kind == lzsd_pkg::KIND_DATA) ? wr_data : 8'd0;
      out_status <= cmd.out_status;
      out_count  <= (cmd.out_kind == lzsd_pkg::KIND_FINISH) ? wc : '0;
      out_last   <= cmd.out_last;
    end
  end

endmodule
`default_nettype wire

[rtl/lzss_stream_decoder_core.sv]
`default_nettype none
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: in_byte; tlast: end_of_stream
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_byte,status,out_count; tuser: kind
//                                              tlast: out_last
// cfg       in   cfg_valid/cfg_ready           cfg_data: out_capacity
//
// each item is accepted in S_IDLE and decoded in S_DECODE; a literal gives its byte there,
// a match gives one byte per cycle from S_COPY while m_axis is not stalled, after a history read;
// no new item is accepted until the copy ends, and there is one history ram read per copied byte.
// a finish result at end of stream comes from S_FINISH, or from S_DECODE at a flag byte.
// rst is synchronous: stream state and handshakes clear, capacity resets to all ones, history is not cleared.
// a stalled m_axis holds the controller until the result register frees; one item may wait
module lzss_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [7:0] out_byte, [9:8] status, [41:10] out_count
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  lzsd_pkg::cmd_t      cmd;
  lzsd_pkg::stat_bus_t sts;
  lzsd_pkg::kind_t     out_kind;
  lzsd_pkg::stat_t     out_status;
  logic [7:0]          out_byte;
  logic [31:0]         out_count;

  assign cfg_ready = 1'b1;

  lzsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzsd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (s_axis_tdata),
    .in_eos     (s_axis_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_count  (out_count),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_count, out_status, out_byte};
  assign m_axis_tuser = out_kind;

endmodule
`default_nettype wire

[rtl/lzsd_checker.sv]
`default_nettype none
`include "lzss_stream_decoder_core_assert.svh"
module lzsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  `LZSD_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result item changed")
  `LZSD_ASSERT_NOW(a_data_clean, clk, rst, m_axis_tvalid && (m_axis_tuser == lzsd_pkg::KIND_DATA), m_axis_tdata[47:8] == 40'd0, "data item carries status or count")
  `LZSD_ASSERT_NOW(a_finish_form, clk, rst, m_axis_tvalid && (m_axis_tuser == lzsd_pkg::KIND_FINISH), m_axis_tlast && (m_axis_tdata[9:0] == 10'd0), "finish item malformed")
  `LZSD_ASSERT_NOW(a_error_form, clk, rst, m_axis_tvalid && (m_axis_tuser == lzsd_pkg::KIND_ERROR), m_axis_tlast && (m_axis_tdata[9:8] != 2'd0) && (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[47:10] == 38'd0), "error item malformed")

endmodule

bind lzss_stream_decoder_core lzsd_checker u_lzsd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
